>>> rtl/core/bqn3_pkg.sv
// Shared types and constants for the three-axis biquad notch core.
`timescale 1ns / 1ps
`default_nettype none

package bqn3_pkg;

	localparam int AXES           = 3;
	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_BITS      = 19;
	localparam int COEF_FRAC_BITS = 16;
	localparam int AXIS_W         = 2;
	localparam int CFG_IDX_W      = 3;

	// Product of one coefficient and one sample, and the sum of five of them
	localparam int PROD_W  = COEF_BITS + SAMPLE_BITS;
	localparam int ACC_W   = PROD_W + 3;
	localparam int SHIFT_W = ACC_W - COEF_FRAC_BITS;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;

	// Coefficient values after reset: unity pass-through
	localparam logic signed [COEF_BITS-1:0] COEF_B0_RST = 19'sd65536;
	localparam logic signed [COEF_BITS-1:0] COEF_ZERO   = '0;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic [AXIS_W-1:0]             axis_t;

	typedef struct packed {
		sample_t sample;
		axis_t   axis;
	} in_beat_t;

	typedef struct packed {
		sample_t filtered;
		axis_t   axis_out;
	} out_beat_t;

	// One history entry per axis: two inputs and two outputs back
	typedef struct packed {
		sample_t x1;
		sample_t x2;
		sample_t y1;
		sample_t y2;
	} hist_t;

endpackage

`default_nettype wire

>>> rtl/core/biquad_notch_three_axis_core.sv
// Top level of the three-axis Direct Form I biquad filter core.
// Path: s1 (history read), s2 (multiply), output register (sum and write back).
// Throughput: one beat per cycle while axes differ and the result channel is not stalled;
// a beat for an axis still in flight waits until that axis's history is written back.
// Reset clears the coefficients to pass-through (b0 = 1.0) and marks every history
// entry empty, so each axis reads as zero history until first written; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module biquad_notch_three_axis_core (
	input  wire                         clk,
	input  wire                         arst_n,
	// sample channel
	input  wire                         in_valid,
	output logic                        in_ready,
	input  bqn3_pkg::in_beat_t          in_data,
	// result channel
	output logic                        out_valid,
	input  wire                         out_ready,
	output bqn3_pkg::out_beat_t         out_data,
	// coefficient write port
	input  wire                         cfg_wr_en,
	input  wire [bqn3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [bqn3_pkg::COEF_BITS-1:0] cfg_data
);

	import bqn3_pkg::*;

	localparam logic signed [SHIFT_W-1:0] SAT_HI = SHIFT_W'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [SHIFT_W-1:0] SAT_LO = -SAT_HI - SHIFT_W'(1);

	// ------------------------------------------------------------------
	// Coefficient registers
	// ------------------------------------------------------------------
	coef_t b0_q, b1_q, b2_q, a1_q, a2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= COEF_B0_RST;
			b1_q <= COEF_ZERO;
			b2_q <= COEF_ZERO;
			a1_q <= COEF_ZERO;
			a2_q <= COEF_ZERO;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_B0:  b0_q <= coef_t'(cfg_data);
				REG_B1:  b1_q <= coef_t'(cfg_data);
				REG_B2:  b2_q <= coef_t'(cfg_data);
				REG_A1:  a1_q <= coef_t'(cfg_data);
				REG_A2:  a2_q <= coef_t'(cfg_data);
				default: ; // drop writes past the last register
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Pipeline control
	// s1: history read data lands; s2: five products; output register:
	// sum, floor shift, saturate, while the history entry is written back.
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, out_vld_q;
	axis_t axis_s1, axis_s2;
	logic in_range_s1, in_range_s2;

	logic adv_out, adv_s2, s1_free, s2_free, hazard, in_acc, in_range;

	assign adv_out = vld_s2 && (!out_vld_q || out_ready);
	assign s2_free = !vld_s2 || adv_out;
	assign adv_s2  = vld_s1 && s2_free;
	assign s1_free = !vld_s1 || adv_s2;

	// Hold a beat whose axis is still being worked on: its history is
	// written only when the earlier beat leaves s2, so a read before then
	// would see stale values.
	assign hazard = (vld_s1 && axis_s1 == in_data.axis) ||
	                (vld_s2 && axis_s2 == in_data.axis);

	assign in_ready = s1_free && !hazard;
	assign in_acc   = in_valid && in_ready;
	assign in_range = in_data.axis < AXIS_W'(AXES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s1_free)
				vld_s1 <= in_acc;
			if (s2_free)
				vld_s2 <= adv_s2;
			if (adv_out)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// History memory: one entry per axis, registered read, one write port.
	// Valid bits stand in for clearing it; an empty entry reads as zero.
	// ------------------------------------------------------------------
	hist_t             hist_mem [AXES];
	logic [AXES-1:0]   hist_vld_q;
	hist_t             rd_s1;
	logic              rd_vld_s1;
	logic              hist_we;
	hist_t             hist_wdata;

	assign hist_we = adv_out && in_range_s2;

	always_ff @(posedge clk) begin
		if (in_acc && in_range)
			rd_s1 <= hist_mem[in_data.axis];
		if (hist_we)
			hist_mem[axis_s2] <= hist_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			if (in_acc)
				rd_vld_s1 <= in_range && hist_vld_q[in_data.axis];
			if (hist_we)
				hist_vld_q[axis_s2] <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 1 payload
	// ------------------------------------------------------------------
	sample_t x_s1;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_s1        <= in_data.sample;
			axis_s1     <= in_data.axis;
			in_range_s1 <= in_range;
		end
	end

	hist_t hist_s1;
	assign hist_s1 = rd_vld_s1 ? rd_s1 : '0;

	// ------------------------------------------------------------------
	// Stage 2: five independent coefficient products
	// ------------------------------------------------------------------
	logic signed [PROD_W-1:0] p_b0_s2, p_b1_s2, p_b2_s2, p_a1_s2, p_a2_s2;
	sample_t x_s2, x1_s2, y1_s2;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			p_b0_s2     <= b0_q * x_s1;
			p_b1_s2     <= b1_q * hist_s1.x1;
			p_b2_s2     <= b2_q * hist_s1.x2;
			p_a1_s2     <= a1_q * hist_s1.y1;
			p_a2_s2     <= a2_q * hist_s1.y2;
			x_s2        <= x_s1;
			x1_s2       <= hist_s1.x1;
			y1_s2       <= hist_s1.y1;
			axis_s2     <= axis_s1;
			in_range_s2 <= in_range_s1;
		end
	end

	// ------------------------------------------------------------------
	// Sum, floor shift (arithmetic shift rounds toward minus infinity), clamp
	// ------------------------------------------------------------------
	logic signed [ACC_W-1:0]   acc;
	logic signed [SHIFT_W-1:0] shifted;
	sample_t                   y_sat;

	always_comb begin
		acc = ACC_W'(p_b0_s2) + ACC_W'(p_b1_s2) + ACC_W'(p_b2_s2)
		    - ACC_W'(p_a1_s2) - ACC_W'(p_a2_s2);
		shifted = SHIFT_W'(acc >>> COEF_FRAC_BITS);
		if (shifted > SAT_HI)
			y_sat = sample_t'(SAT_HI);
		else if (shifted < SAT_LO)
			y_sat = sample_t'(SAT_LO);
		else
			y_sat = sample_t'(shifted);
	end

	// Advance both delay lines of the axis
	always_comb begin
		hist_wdata.x1 = x_s2;
		hist_wdata.x2 = x1_s2;
		hist_wdata.y1 = y_sat;
		hist_wdata.y2 = y1_s2;
	end

	// ------------------------------------------------------------------
	// Output register: out-of-range axes give zero and leave history alone
	// ------------------------------------------------------------------
	out_beat_t out_q;

	always_ff @(posedge clk) begin
		if (adv_out) begin
			out_q.filtered <= in_range_s2 ? y_sat : '0;
			out_q.axis_out <= axis_s2;
		end
	end

	assign out_valid = out_vld_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire
